@@ rtl/mcstb_pkg.sv @@
// Package for the multi-channel soft timer bank.
// Field widths, default sizes and operation codes; no dependencies.
`default_nettype none

package mcstb_pkg;

  localparam int NUM_TIMERS_DEF  = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int OP_W     = 3;
  localparam int INDEX_W  = 4;
  localparam int PERIOD_W = 32;

  // reports per service sweep
  localparam int MAX_REPORTS = 16;
  localparam int REPORT_W    = $clog2(MAX_REPORTS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ARM     = 3'd0,
    OP_DISARM  = 3'd1,
    OP_START   = 3'd2,
    OP_STOP    = 3'd3,
    OP_TICK    = 3'd4,
    OP_SERVICE = 3'd5
  } op_t;

endpackage

`default_nettype wire

@@ rtl/mcstb_in_if.sv @@
// Input item channel of the timer bank: operation, index, period, repeat mode.
// Depends on mcstb_pkg.
`default_nettype none

interface mcstb_in_if import mcstb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [INDEX_W-1:0]  timer_index;
  logic [PERIOD_W-1:0] reload_ticks;
  logic                repeat_mode;

  modport source (output valid, operation, timer_index, reload_ticks, repeat_mode,
                  input ready);
  modport sink   (input valid, operation, timer_index, reload_ticks, repeat_mode,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/mcstb_out_if.sv @@
// Result item channel of the timer bank: fired index and sweep markers.
// Depends on mcstb_pkg.
`default_nettype none

interface mcstb_out_if import mcstb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] fired_index;
  logic               fired;
  logic               last_result;

  modport source (output valid, fired_index, fired, last_result, input ready);
  modport sink   (input valid, fired_index, fired, last_result, output ready);
endinterface

`default_nettype wire

@@ rtl/mcstb_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module mcstb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/multi_channel_soft_timer_bank_top.sv @@
// Multi-channel soft timer bank: count/reload pairs in one RAM, flags in flops.
// Arm, disarm and start finish as they are taken; stop reads the entry, writes it
// back and settles. Tick and service step through the RAM one entry per cycle,
// then write back the last entry, and an empty service sweep emits a marker;
// service also waits whenever a result item is held by the sink.
// Reset (rst_n, synchronous) clears all flags and control; the RAM is not
// cleared as an entry's contents only matter once armed.
// Depends on mcstb_pkg, mcstb_in_if, mcstb_out_if, mcstb_ram.
`default_nettype none

module multi_channel_soft_timer_bank_top import mcstb_pkg::*; #(
  parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mcstb_in_if.sink     in_if,
  mcstb_out_if.source  out_if
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int ENT_W = 2 * COUNT_WIDTH;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DRAIN, S_EMPTY} state_t;

  state_t                  state_r, state_nxt;
  logic                    svc_r, svc_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [REPORT_W-1:0]     n_r, n_nxt;
  logic [NUM_TIMERS-1:0]   in_use_r, in_use_nxt;
  logic [NUM_TIMERS-1:0]   en_r, en_nxt;
  logic [NUM_TIMERS-1:0]   rep_r, rep_nxt;
  logic [NUM_TIMERS-1:0]   exp_r, exp_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                    rd_tick_r, rd_tick_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]      out_idx_r, out_idx_nxt;
  logic                    out_fired_r, out_fired_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [ENT_W-1:0]        ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [ENT_W-1:0]        ram_rdata;

  logic                    accept;
  op_t                     op;
  logic                    idx_ok;
  logic [IDX_W-1:0]        in_idx;
  logic [COUNT_WIDTH-1:0]  period;
  logic [NUM_TIMERS-1:0]   pending;
  logic [NUM_TIMERS-1:0]   above;
  logic                    cur_hit;
  logic                    cur_last;
  logic                    cur_tick;
  logic                    can_emit;
  logic                    out_load;
  logic [COUNT_WIDTH-1:0]  cnt;
  logic [COUNT_WIDTH-1:0]  rel;
  logic [COUNT_WIDTH-1:0]  dec;

  mcstb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign op          = op_t'(in_if.operation);
  assign idx_ok      = int'(in_if.timer_index) < NUM_TIMERS;
  assign in_idx      = IDX_W'(in_if.timer_index);
  assign period      = COUNT_WIDTH'(in_if.reload_ticks);

  assign pending  = in_use_r & exp_r;
  assign above    = (pending >> idx_r) >> 1;
  assign cur_hit  = svc_r && pending[idx_r] && (n_r < REPORT_W'(MAX_REPORTS));
  assign cur_last = (n_r == REPORT_W'(MAX_REPORTS - 1)) || !(|above);
  assign cur_tick = !svc_r && in_use_r[idx_r] && en_r[idx_r];
  assign can_emit = !out_valid_r || out_if.ready;

  // entry layout: reload above count
  assign cnt = ram_rdata[COUNT_WIDTH-1:0];
  assign rel = ram_rdata[ENT_W-1:COUNT_WIDTH];
  assign dec = (cnt != '0) ? cnt - COUNT_WIDTH'(1) : cnt;

  always_comb begin
    state_nxt     = state_r;
    svc_nxt       = svc_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    in_use_nxt    = in_use_r;
    en_nxt        = en_r;
    rep_nxt       = rep_r;
    exp_nxt       = exp_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    rd_tick_nxt   = rd_tick_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_idx_nxt   = out_idx_r;
    out_fired_nxt = out_fired_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = rd_idx_r;
    ram_wdata     = {rel, (rd_tick_r ? dec : rel)};
    ram_raddr     = idx_r;

    // write-back stage
    if (rd_vld_r) begin
      ram_we = 1'b1;
      if (rd_tick_r && (dec == '0)) begin
        exp_nxt[rd_idx_r] = 1'b1;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_ARM: begin
              if (idx_ok) begin
                ram_we             = 1'b1;
                ram_waddr          = in_idx;
                ram_wdata          = {period, period};
                en_nxt[in_idx]     = 1'b0;
                exp_nxt[in_idx]    = 1'b0;
                rep_nxt[in_idx]    = in_if.repeat_mode;
                in_use_nxt[in_idx] = 1'b1;
              end
            end
            OP_DISARM: begin
              if (idx_ok) begin
                en_nxt[in_idx]     = 1'b0;
                exp_nxt[in_idx]    = 1'b0;
                rep_nxt[in_idx]    = 1'b0;
                in_use_nxt[in_idx] = 1'b0;
              end
            end
            OP_START: begin
              if (idx_ok) begin
                en_nxt[in_idx] = 1'b1;
              end
            end
            OP_STOP: begin
              if (idx_ok) begin
                en_nxt[in_idx] = 1'b0;
                ram_raddr      = in_idx;
                rd_vld_nxt     = 1'b1;
                rd_idx_nxt     = in_idx;
                rd_tick_nxt    = 1'b0;
                svc_nxt        = 1'b0;
                state_nxt      = S_DRAIN;
              end
            end
            OP_TICK: begin
              svc_nxt   = 1'b0;
              idx_nxt   = '0;
              state_nxt = S_SWEEP;
            end
            OP_SERVICE: begin
              svc_nxt   = 1'b1;
              idx_nxt   = '0;
              n_nxt     = '0;
              state_nxt = S_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end
      S_SWEEP: begin
        if (!(cur_hit && !can_emit)) begin
          if (cur_hit) begin
            out_load       = 1'b1;
            out_valid_nxt  = 1'b1;
            out_idx_nxt    = INDEX_W'(idx_r);
            out_fired_nxt  = 1'b1;
            out_last_nxt   = cur_last;
            en_nxt[idx_r]  = rep_r[idx_r];
            exp_nxt[idx_r] = 1'b0;
            n_nxt          = n_r + REPORT_W'(1);
            rd_vld_nxt     = 1'b1;
            rd_idx_nxt     = idx_r;
            rd_tick_nxt    = 1'b0;
          end
          if (cur_tick) begin
            rd_vld_nxt  = 1'b1;
            rd_idx_nxt  = idx_r;
            rd_tick_nxt = 1'b1;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_DRAIN;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r) begin
          state_nxt = (svc_r && (n_r == '0)) ? S_EMPTY : S_IDLE;
        end
      end
      S_EMPTY: begin
        if (can_emit) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = '0;
          out_fired_nxt = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      svc_r       <= 1'b0;
      idx_r       <= '0;
      n_r         <= '0;
      in_use_r    <= '0;
      en_r        <= '0;
      rep_r       <= '0;
      exp_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      svc_r       <= svc_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      in_use_r    <= in_use_nxt;
      en_r        <= en_nxt;
      rep_r       <= rep_nxt;
      exp_r       <= exp_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r    <= rd_idx_nxt;
    rd_tick_r   <= rd_tick_nxt;
    out_idx_r   <= out_idx_nxt;
    out_fired_r <= out_fired_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.fired_index = out_idx_r;
  assign out_if.fired       = out_fired_r;
  assign out_if.last_result = out_last_r;

`ifndef SYNTHESIS
  a_idle_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> !rd_vld_r)
    else $error("item taken with a write-back pending");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> can_emit)
    else $error("result register overwritten");

  a_exp_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r & ~in_use_r) == '0)
    else $error("expired flag on an unused timer");

  a_report_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= REPORT_W'(MAX_REPORTS))
    else $error("too many reports in one sweep");
`endif

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Testbench for the multi-channel soft timer bank: random and directed timer items,
// a scoreboard class that predicts every sweep result, and random idling on both sides.
// Depends on mcstb_pkg, mcstb_in_if, mcstb_out_if and multi_channel_soft_timer_bank_top.

module testbench;
  import mcstb_pkg::*;

  localparam int NT           = NUM_TIMERS_DEF;
  localparam int CW           = COUNT_WIDTH_DEF;
  localparam int ITEM_TARGET  = 470;
  localparam int TAIL_CYCLES  = 40;
  localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;

  typedef struct {
    logic [INDEX_W-1:0] fired_index;
    logic               fired;
    logic               last_result;
  } fired_rec_t;

  class timer_bank_scoreboard;
    bit [CW-1:0] count_q[NT];
    bit [CW-1:0] reload_q[NT];
    bit          in_use_q[NT];
    bit          enabled_q[NT];
    bit          repeat_q[NT];
    bit          expired_q[NT];
    fired_rec_t  expected_fires[$];
    int          errors;
    int          fires_seen;
    int          empty_sweeps;
    int          widest_sweep;
    int          items_noted;

    function new();
      errors       = 0;
      fires_seen   = 0;
      empty_sweeps = 0;
      widest_sweep = 0;
      items_noted  = 0;
    endfunction

    function int pending();
      return expected_fires.size();
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void push_fire(int idx, bit fired, bit last);
      fired_rec_t rec;
      rec.fired_index = idx[INDEX_W-1:0];
      rec.fired       = fired;
      rec.last_result = last;
      expected_fires.push_back(rec);
    endfunction

    function void sweep_service();
      int n;
      n = 0;
      for (int i = 0; i < NT; i++) begin
        if (n < MAX_REPORTS && in_use_q[i] && expired_q[i]) begin
          count_q[i]   = reload_q[i];
          expired_q[i] = 1'b0;
          enabled_q[i] = repeat_q[i];
          push_fire(i, 1'b1, 1'b0);
          n++;
        end
      end
      if (n == 0) begin
        push_fire(0, 1'b0, 1'b1);
      end else begin
        expected_fires[expected_fires.size()-1].last_result = 1'b1;
      end
      if (n > widest_sweep) widest_sweep = n;
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                            logic [PERIOD_W-1:0] period, logic rep);
      bit ok;
      ok = int'(idx) < NT;
      items_noted++;
      case (op)
        OP_ARM: begin
          if (ok) begin
            count_q[idx]   = period[CW-1:0];
            reload_q[idx]  = period[CW-1:0];
            enabled_q[idx] = 1'b0;
            expired_q[idx] = 1'b0;
            repeat_q[idx]  = rep;
            in_use_q[idx]  = 1'b1;
          end
        end
        OP_DISARM: begin
          if (ok) begin
            enabled_q[idx] = 1'b0;
            expired_q[idx] = 1'b0;
            repeat_q[idx]  = 1'b0;
            in_use_q[idx]  = 1'b0;
          end
        end
        OP_START: begin
          if (ok) enabled_q[idx] = 1'b1;
        end
        OP_STOP: begin
          if (ok) begin
            enabled_q[idx] = 1'b0;
            count_q[idx]   = reload_q[idx];
          end
        end
        OP_TICK: begin
          for (int i = 0; i < NT; i++) begin
            if (in_use_q[i] && enabled_q[i]) begin
              if (count_q[i] != '0) count_q[i] = count_q[i] - 1'b1;
              if (count_q[i] == '0) expired_q[i] = 1'b1;
            end
          end
        end
        OP_SERVICE: sweep_service();
        default: ;
      endcase
    endfunction

    task check_result(logic [INDEX_W-1:0] idx, logic fired, logic last);
      fired_rec_t want;
      if (expected_fires.size() == 0) begin
        report_mismatch($sformatf("unexpected result index %0d fired %b last %b",
                                  idx, fired, last));
      end else begin
        want = expected_fires.pop_front();
        if (fired !== want.fired)
          report_mismatch($sformatf("fired %b, predicted %b", fired, want.fired));
        if (idx !== want.fired_index)
          report_mismatch($sformatf("fired_index %0d, predicted %0d", idx, want.fired_index));
        if (last !== want.last_result)
          report_mismatch($sformatf("last_result %b, predicted %b", last, want.last_result));
        if (want.fired) fires_seen++;
        else empty_sweeps++;
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  mcstb_in_if  in_ch ();
  mcstb_out_if out_ch ();

  multi_channel_soft_timer_bank_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  timer_bank_scoreboard sb = new();

  int burst_left = 0;
  int counted    = 0;
  int rx_mode    = 0;
  int rx_left    = 0;
  int rx_cyc     = 0;
  bit swept_a    = 0;
  bit swept_b    = 0;
  bit drained    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver stall pattern
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(32, 200);
      end
      rx_left--;
      rx_cyc++;
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ((rx_cyc % 7) < 4);
      endcase
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_result(out_ch.fired_index, out_ch.fired, out_ch.last_result);
    end
  end

  task send_item(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                 logic [PERIOD_W-1:0] period, logic rep);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.timer_index  <= idx;
    in_ch.reload_ticks <= period;
    in_ch.repeat_mode  <= rep;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_item(op, idx, period, rep);
    counted++;
  endtask

  task drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function logic [PERIOD_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return PERIOD_W'($urandom_range(0, 4));
    if (r < 85) return PERIOD_W'($urandom_range(5, 40));
    if (r < 95) return PERIOD_W'($urandom);
    return (r < 98) ? '1 : {1'b1, {(PERIOD_W-1){1'b0}}};
  endfunction

  // arm every timer, start them all, tick and sweep: fills one service with reports
  task run_full_sweep();
    for (int i = 0; i < NT; i++)
      send_item(OP_ARM, INDEX_W'(i), PERIOD_W'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
    for (int i = 0; i < NT; i++)
      send_item(OP_START, INDEX_W'(i), PERIOD_W'($urandom), 1'($urandom_range(0, 1)));
    repeat (3) send_item(OP_TICK, INDEX_W'($urandom), PERIOD_W'($urandom), 1'b0);
    send_item(OP_SERVICE, INDEX_W'($urandom), PERIOD_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task send_random_item();
    int r;
    logic [OP_W-1:0] op;
    r = $urandom_range(0, 99);
    if (r < 30)      op = OP_TICK;
    else if (r < 48) op = OP_SERVICE;
    else if (r < 64) op = OP_ARM;
    else if (r < 79) op = OP_START;
    else if (r < 87) op = OP_STOP;
    else if (r < 94) op = OP_DISARM;
    else             op = (r < 97) ? OP_RESERVED_LO : OP_RESERVED_HI;
    send_item(op, INDEX_W'($urandom), pick_period(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_TICK;
    in_ch.timer_index  <= '0;
    in_ch.reload_ticks <= '0;
    in_ch.repeat_mode  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    send_item(OP_SERVICE, 4'd0, '0, 1'b0);
    send_item(OP_ARM, 4'd0, '0, 1'b1);
    send_item(OP_ARM, 4'd15, '1, 1'b0);
    send_item(OP_ARM, 4'd5, 32'd2, 1'b0);
    send_item(OP_ARM, 4'd3, 32'd1, 1'b1);
    send_item(OP_START, 4'd0, '0, 1'b0);
    send_item(OP_START, 4'd5, '0, 1'b0);
    send_item(OP_START, 4'd15, '0, 1'b0);
    send_item(OP_START, 4'd3, '0, 1'b0);
    send_item(OP_TICK, 4'd0, '0, 1'b0);
    send_item(OP_SERVICE, 4'd0, '0, 1'b0);
    send_item(OP_TICK, 4'd0, '0, 1'b0);
    send_item(OP_STOP, 4'd3, '0, 1'b0);
    send_item(OP_SERVICE, 4'd0, '0, 1'b0);
    send_item(OP_RESERVED_LO, 4'd15, '1, 1'b1);
    send_item(OP_RESERVED_HI, 4'd15, '1, 1'b1);
    send_item(OP_START, 4'd9, '0, 1'b0);
    send_item(OP_STOP, 4'd10, '0, 1'b0);
    send_item(OP_ARM, 4'd0, 32'd3, 1'b0);
    send_item(OP_DISARM, 4'd15, '0, 1'b0);
    send_item(OP_TICK, 4'd0, '0, 1'b0);
    send_item(OP_SERVICE, 4'd0, '0, 1'b0);
    send_item(OP_ARM, 4'd12, 32'h5555_AAAA, 1'b1);
    drain_results();

    // random part
    while (counted < ITEM_TARGET) begin
      if (!swept_a && counted >= 120) begin
        swept_a = 1;
        run_full_sweep();
      end else if (!drained && counted >= 240) begin
        drained = 1;
        drain_results();
      end else if (!swept_b && counted >= 360) begin
        swept_b = 1;
        run_full_sweep();
      end else begin
        send_random_item();
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d items: %0d timer expiries reported, %0d empty sweeps,",
             sb.items_noted, sb.fires_seen, sb.empty_sweeps);
    $display("widest sweep %0d reports, %0d mismatches.", sb.widest_sweep, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
